/* src/mf3a_pkg.sv */
// Shared constants and types of the adaptive 3x3 median filter.
// No dependencies; every other file of the block imports it.
package mf3a_pkg;

    localparam int COL_BITS      = 12;
    localparam int ROW_BITS      = 16;
    localparam int WIDTH_BITS    = 13;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int OQ_DEPTH      = 8;
    localparam int OQ_AW         = $clog2(OQ_DEPTH);

    typedef struct packed {
        logic [COL_BITS-1:0] col;
        logic [ROW_BITS-1:0] row;
        logic                frame_end;
    } t_meta;

endpackage

/* src/mf3a_if.sv */
// Valid/ready stream interfaces: input pixel words and filtered result words.
// Depends on mf3a_pkg for coordinate widths.
interface mf3a_pix_if #(
    parameter int PIXEL_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] pixel;

    modport source (output valid, pixel, input ready);
    modport sink   (input valid, pixel, output ready);
endinterface

interface mf3a_res_if #(
    parameter int PIXEL_BITS = 16
) ();
    import mf3a_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] filtered;
    logic [COL_BITS-1:0]          out_col;
    logic [ROW_BITS-1:0]          out_row;
    logic                         frame_end;

    modport source (output valid, filtered, out_col, out_row, frame_end, input ready);
    modport sink   (input valid, filtered, out_col, out_row, frame_end, output ready);
endinterface

/* src/mf3a_filter.sv */
// Three-stage median datapath: column sort, column combine, final median
// with adaptive switching. Depends on mf3a_pkg.
module mf3a_filter #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [2:0][2:0][PIXEL_BITS-1:0]     i_win,
    input  mf3a_pkg::t_meta                     i_meta,
    input  logic                                i_adapt,
    output logic                                o_valid,
    output logic signed [PIXEL_BITS-1:0]        o_pix,
    output mf3a_pkg::t_meta                     o_meta
);
    import mf3a_pkg::*;

    typedef logic signed [PIXEL_BITS-1:0] t_pix;

    function automatic t_pix f_min(input t_pix a, input t_pix b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_pix f_max(input t_pix a, input t_pix b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_pix f_min3(input t_pix a, input t_pix b, input t_pix c);
        return f_min(f_min(a, b), c);
    endfunction

    function automatic t_pix f_max3(input t_pix a, input t_pix b, input t_pix c);
        return f_max(f_max(a, b), c);
    endfunction

    function automatic t_pix f_med3(input t_pix a, input t_pix b, input t_pix c);
        return f_max(f_min(a, b), f_min(f_max(a, b), c));
    endfunction

    logic  r2_valid;
    t_pix  r2_lo [3];
    t_pix  r2_md [3];
    t_pix  r2_hi [3];
    t_pix  r2_ctr;
    t_meta r2_meta;

    logic  r3_valid;
    t_pix  r3_mxlo;
    t_pix  r3_mdmd;
    t_pix  r3_mnhi;
    t_pix  r3_wmax;
    t_pix  r3_wmin;
    t_pix  r3_ctr;
    t_meta r3_meta;

    logic  r4_valid;
    t_pix  r4_pix;
    t_meta r4_meta;

    t_pix  med;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            r2_valid <= i_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r2_lo[j] <= f_min3(i_win[0][j], i_win[1][j], i_win[2][j]);
            r2_md[j] <= f_med3(i_win[0][j], i_win[1][j], i_win[2][j]);
            r2_hi[j] <= f_max3(i_win[0][j], i_win[1][j], i_win[2][j]);
        end
        r2_ctr  <= i_win[1][1];
        r2_meta <= i_meta;
    end

    always_ff @(posedge i_clk) begin
        r3_mxlo <= f_max3(r2_lo[0], r2_lo[1], r2_lo[2]);
        r3_mdmd <= f_med3(r2_md[0], r2_md[1], r2_md[2]);
        r3_mnhi <= f_min3(r2_hi[0], r2_hi[1], r2_hi[2]);
        r3_wmax <= f_max3(r2_hi[0], r2_hi[1], r2_hi[2]);
        r3_wmin <= f_min3(r2_lo[0], r2_lo[1], r2_lo[2]);
        r3_ctr  <= r2_ctr;
        r3_meta <= r2_meta;
    end

    assign med = f_med3(r3_mxlo, r3_mdmd, r3_mnhi);

    // adaptive: keep the centre unless it is a window extreme
    always_ff @(posedge i_clk) begin
        if (i_adapt && (r3_ctr != r3_wmax) && (r3_ctr != r3_wmin)) begin
            r4_pix <= r3_ctr;
        end else begin
            r4_pix <= med;
        end
        r4_meta <= r3_meta;
    end

    assign o_valid = r4_valid;
    assign o_pix   = r4_pix;
    assign o_meta  = r4_meta;

endmodule

/* src/mf3a_ofifo.sv */
// Output queue of result words that drives the result stream.
// Depends on mf3a_pkg and mf3a_res_if; the producer never overfills it.
module mf3a_ofifo #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic signed [PIXEL_BITS-1:0] i_pix,
    input  mf3a_pkg::t_meta              i_meta,
    mf3a_res_if.source                   o_res
);
    import mf3a_pkg::*;

    logic [PIXEL_BITS-1:0] r_pix  [OQ_DEPTH];
    t_meta                 r_meta [OQ_DEPTH];
    logic [OQ_AW-1:0]      r_wp;
    logic [OQ_AW-1:0]      r_rp;
    logic [OQ_AW:0]        r_cnt;
    logic [OQ_AW:0]        n_cnt;
    logic                  pop;

    assign pop = o_res.valid && o_res.ready;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_pix[r_wp]  <= i_pix;
            r_meta[r_wp] <= i_meta;
        end
    end

    assign o_res.valid     = (r_cnt != '0);
    assign o_res.filtered  = $signed(r_pix[r_rp]);
    assign o_res.out_col   = r_meta[r_rp].col;
    assign o_res.out_row   = r_meta[r_rp].row;
    assign o_res.frame_end = r_meta[r_rp].frame_end;

endmodule

/* src/median_filter_3x3_adaptive_top.sv */
// Top level of the adaptive 3x3 median filter: line store, window, result sequencer.
// Depends on mf3a_pkg, mf3a_if, mf3a_filter and mf3a_ofifo.
//
//   port        dir   word contents
//   i_in        sink  pixel (PIXEL_BITS, signed), raster order
//   o_out       src   filtered, out_col, out_row, frame_end
//   i_cfg_*     in    we / idx / data: 0 width, 1 height, 2 adaptive mode
//
// One pixel per cycle while no earlier result words wait to issue; where a pixel owes more
// than one word it holds the input: a row end in row 1 or later owes two words, a last-row
// pixel past column 0 owes two and the frame's last pixel four, issued one at a time by the
// single-issue result sequencer that feeds the registered filter datapath.
// Synchronous reset clears control and window; the line store is not cleared.
// An 8-word output queue with issue credits absorbs o_out stalls.
module median_filter_3x3_adaptive_top #(
    parameter int MAX_WIDTH  = 4096,
    parameter int PIXEL_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    mf3a_pix_if.sink                           i_in,
    mf3a_res_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [mf3a_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [mf3a_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import mf3a_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WB = ($clog2(MAX_WIDTH + 1) > WIDTH_BITS) ? $clog2(MAX_WIDTH + 1)
                                                             : WIDTH_BITS;
    localparam int K_MID  = 0;
    localparam int K_END  = 1;
    localparam int K_LMID = 2;
    localparam int K_LEND = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_ADAPT  = 2'd2
    } t_cfg_reg;

    typedef logic [PIXEL_BITS-1:0] t_raw;

    // configuration
    logic [WIDTH_BITS-1:0] r_width;
    logic [ROW_BITS-1:0]   r_height;
    logic                  r_adapt;

    // position of the next pixel
    logic [COL_BITS-1:0]   r_col;
    logic [ROW_BITS-1:0]   r_row;
    logic [COL_BITS-1:0]   n_col;
    logic [ROW_BITS-1:0]   n_row;

    logic [WB-1:0]         w_last;
    logic [ROW_BITS-1:0]   h_last;
    logic                  last_col;
    logic                  last_row;
    logic [AW-1:0]         idx;
    logic                  in_acc;

    // line store: upper half row r-1, lower half row r-2
    logic [2*PIXEL_BITS-1:0] r_lmem [MAX_WIDTH];
    logic [2*PIXEL_BITS-1:0] r_rdata;

    // memory read stage
    logic                  r_b_valid;
    t_raw                  r_b_pix;
    logic [COL_BITS-1:0]   r_b_col;
    logic [ROW_BITS-1:0]   r_b_row;
    logic                  r_b_lc;
    logic                  r_b_lr;
    logic [AW-1:0]         r_b_addr;

    // window [row slot][col slot] and sequencer
    logic [2:0][2:0][PIXEL_BITS-1:0] r_win;
    logic [3:0]            r_c_pend;
    logic [3:0]            n_pend;
    logic [3:0]            pend_left;
    logic [3:0]            low;
    logic [COL_BITS-1:0]   r_c_col;
    logic [ROW_BITS-1:0]   r_c_row;
    logic                  r_c_rge2;
    logic                  r_c_cge2;
    logic                  issue;
    logic                  c_take;

    logic [OQ_AW:0]        r_cred;
    logic [OQ_AW:0]        n_cred;
    logic                  pop;

    logic                  sel_lrow;
    logic                  sel_end;
    logic [1:0]            rs [3];
    logic [1:0]            cs [3];
    logic [2:0][2:0][PIXEL_BITS-1:0] sel_win;
    t_meta                 sel_meta;

    logic                  f_valid;
    logic signed [PIXEL_BITS-1:0] f_pix;
    t_meta                 f_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_BITS'(640);
            r_height <= ROW_BITS'(480);
            r_adapt  <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_WIDTH:  r_width  <= i_cfg_data[WIDTH_BITS-1:0];
                REG_HEIGHT: r_height <= i_cfg_data[ROW_BITS-1:0];
                REG_ADAPT:  r_adapt  <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        if (r_width < WIDTH_BITS'(2)) begin
            w_last = WB'(1);
        end else if (WB'(r_width) > WB'(MAX_WIDTH)) begin
            w_last = WB'(MAX_WIDTH - 1);
        end else begin
            w_last = WB'(r_width) - WB'(1);
        end
        h_last   = (r_height < ROW_BITS'(2)) ? ROW_BITS'(1) : r_height - ROW_BITS'(1);
        last_col = WB'(r_col) >= w_last;
        last_row = r_row >= h_last;
        if (WB'(r_col) >= WB'(MAX_WIDTH)) begin
            idx = AW'(MAX_WIDTH - 1);
        end else begin
            idx = AW'(r_col);
        end
    end

    // sequencer: one result word per cycle while issue credits remain, lowest pending kind first
    assign low       = r_c_pend & (~r_c_pend + 4'd1);
    assign issue     = (r_c_pend != 4'd0) && (r_cred < (OQ_AW + 1)'(OQ_DEPTH));
    assign pend_left = issue ? (r_c_pend & ~low) : r_c_pend;
    assign c_take    = r_b_valid && (pend_left == 4'd0);
    assign in_acc    = i_in.valid && i_in.ready;
    assign pop       = o_out.valid && o_out.ready;

    assign i_in.ready = !r_b_valid || c_take;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (in_acc) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
        n_pend = pend_left;
        if (c_take) begin
            n_pend[K_MID]  = (r_b_row != '0) && (r_b_col != '0);
            n_pend[K_END]  = (r_b_row != '0) && r_b_lc;
            n_pend[K_LMID] = r_b_lr && (r_b_col != '0);
            n_pend[K_LEND] = r_b_lr && r_b_lc;
        end
        n_cred = r_cred;
        if (issue && !pop) begin
            n_cred = r_cred + 1'b1;
        end else if (!issue && pop) begin
            n_cred = r_cred - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_b_valid <= 1'b0;
            r_c_pend  <= '0;
            r_cred    <= '0;
            r_win     <= '0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_c_pend <= n_pend;
            r_cred   <= n_cred;
            if (in_acc) begin
                r_b_valid <= 1'b1;
            end else if (c_take) begin
                r_b_valid <= 1'b0;
            end
            if (c_take) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k][0] <= r_win[k][1];
                    r_win[k][1] <= r_win[k][2];
                end
                r_win[0][2] <= r_rdata[PIXEL_BITS-1:0];
                r_win[1][2] <= r_rdata[2*PIXEL_BITS-1:PIXEL_BITS];
                r_win[2][2] <= r_b_pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b_pix  <= i_in.pixel;
            r_b_col  <= r_col;
            r_b_row  <= r_row;
            r_b_lc   <= last_col;
            r_b_lr   <= last_row;
            r_b_addr <= idx;
        end
        if (c_take) begin
            r_c_col  <= r_b_col;
            r_c_row  <= r_b_row;
            r_c_rge2 <= r_b_row >= ROW_BITS'(2);
            r_c_cge2 <= r_b_col >= COL_BITS'(2);
        end
    end

    // read-modify-write of the line store; rdata holds while the stage stalls
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rdata <= r_lmem[idx];
        end
        if (r_b_valid) begin
            r_lmem[r_b_addr] <= {r_b_pix, r_rdata[2*PIXEL_BITS-1:PIXEL_BITS]};
        end
    end

    // mirrored slot selection for the issued word
    always_comb begin
        sel_lrow = low[K_LMID] || low[K_LEND];
        sel_end  = low[K_END] || low[K_LEND];
        if (sel_lrow) begin
            rs[0] = 2'd1;
            rs[1] = 2'd2;
            rs[2] = 2'd1;
        end else begin
            rs[0] = r_c_rge2 ? 2'd0 : 2'd2;
            rs[1] = 2'd1;
            rs[2] = 2'd2;
        end
        if (sel_end) begin
            cs[0] = 2'd1;
            cs[1] = 2'd2;
            cs[2] = 2'd1;
        end else begin
            cs[0] = r_c_cge2 ? 2'd0 : 2'd2;
            cs[1] = 2'd1;
            cs[2] = 2'd2;
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                sel_win[i][j] = r_win[rs[i]][cs[j]];
            end
        end
        sel_meta.col       = sel_end ? r_c_col : r_c_col - 1'b1;
        sel_meta.row       = sel_lrow ? r_c_row : r_c_row - 1'b1;
        sel_meta.frame_end = low[K_LEND];
    end

    mf3a_filter #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (issue),
        .i_win   (sel_win),
        .i_meta  (sel_meta),
        .i_adapt (r_adapt),
        .o_valid (f_valid),
        .o_pix   (f_pix),
        .o_meta  (f_meta)
    );

    mf3a_ofifo #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_pix   (f_pix),
        .i_meta  (f_meta),
        .o_res   (o_out)
    );

`ifndef SYNTHESIS
    a_cred_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cred <= (OQ_AW + 1)'(OQ_DEPTH))
        else $error("issue credits exceed queue depth");

    a_out_needs_cred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cred == '0) |-> !o_out.valid)
        else $error("result word without an issued credit");

    a_read_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !c_take) |-> !i_in.ready)
        else $error("pixel accepted while line store read stage is held");

    a_take_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_take && !in_acc) |=> !r_b_valid)
        else $error("read stage not drained after window shift");
`endif

endmodule

/* tb/sv/tb_top.sv */
// Testbench for the adaptive 3x3 median filter: drives pixel frames, writes the size and
// mode registers between frames and mid-frame, and checks every filtered word against a local window model.
// Depends on mf3a_pkg, mf3a_if and median_filter_3x3_adaptive_top.
`timescale 1ns / 100ps

module tb_top;
    import mf3a_pkg::*;

    localparam int PIX_W         = 16;
    localparam int LINE_DEPTH    = 4096;
    localparam int SETTLE_CYCLES = 32;
    localparam int RANDOM_PIXELS = 220;
    localparam int WIDE_PIXELS   = 24;
    localparam int TIMEOUT_NS    = 1_000_000;
    localparam int MAX_REPORTS   = 100;

    typedef logic signed [PIX_W-1:0] t_pix;

    localparam t_pix PIX_MAX = 16'sh7FFF;
    localparam t_pix PIX_MIN = 16'sh8000;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_WIDTH    = 2'd0,
        REG_HEIGHT   = 2'd1,
        REG_ADAPTIVE = 2'd2,
        REG_SPARE    = 2'd3
    } t_reg_idx;

    typedef enum int {PIX_FULL, PIX_NARROW, PIX_EXTREME, PIX_IMPULSE} t_pix_style;

    typedef struct packed {
        logic signed [PIX_W-1:0] filtered;
        logic [COL_BITS-1:0]     col;
        logic [ROW_BITS-1:0]     row;
        logic                    frame_end;
    } t_filt_word;

    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     cfg_we   = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    mf3a_pix_if #(.PIXEL_BITS(PIX_W)) pix_bus ();
    mf3a_res_if #(.PIXEL_BITS(PIX_W)) res_bus ();

    median_filter_3x3_adaptive_top #(
        .MAX_WIDTH (LINE_DEPTH),
        .PIXEL_BITS(PIX_W)
    ) i_dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_in      (pix_bus),
        .o_out     (res_bus),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // register shadows and window model
    logic [WIDTH_BITS-1:0] shd_width;
    logic [ROW_BITS-1:0]   shd_height;
    logic                  shd_adaptive;
    t_pix                  line_up1 [LINE_DEPTH];
    t_pix                  line_up2 [LINE_DEPTH];
    t_pix                  win [9];
    logic [COL_BITS-1:0]   next_col;
    logic [ROW_BITS-1:0]   next_row;
    t_filt_word            medians_due[$];

    int error_count   = 0;
    int words_checked = 0;
    int pixels_sent   = 0;
    int frames_done   = 0;
    bit idling_on     = 1'b1;
    int stall_left    = 0;

    function automatic t_pix lo3(t_pix a, t_pix b, t_pix c);
        t_pix m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic t_pix hi3(t_pix a, t_pix b, t_pix c);
        t_pix m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic t_pix mid3(t_pix a, t_pix b, t_pix c);
        t_pix l, h, t;
        l = (a < b) ? a : b;
        h = (a < b) ? b : a;
        t = (h < c) ? h : c;
        return (l > t) ? l : t;
    endfunction

    // rows and columns are window slots; mirrored borders pick repeated slots
    function automatic t_pix window_median(int rt, int rm, int rb, int c0, int c1, int c2);
        int   cs [3];
        t_pix lo [3];
        t_pix md [3];
        t_pix hi [3];
        t_pix med, centre;
        cs = '{c0, c1, c2};
        for (int k = 0; k < 3; k++) begin
            lo[k] = lo3(win[rt*3+cs[k]], win[rm*3+cs[k]], win[rb*3+cs[k]]);
            md[k] = mid3(win[rt*3+cs[k]], win[rm*3+cs[k]], win[rb*3+cs[k]]);
            hi[k] = hi3(win[rt*3+cs[k]], win[rm*3+cs[k]], win[rb*3+cs[k]]);
        end
        med    = mid3(hi3(lo[0], lo[1], lo[2]), mid3(md[0], md[1], md[2]),
                      lo3(hi[0], hi[1], hi[2]));
        centre = win[rm*3+c1];
        if (shd_adaptive && centre != hi3(hi[0], hi[1], hi[2])
                && centre != lo3(lo[0], lo[1], lo[2])) begin
            return centre;
        end
        return med;
    endfunction

    function automatic void push_median(t_pix v, int col, int row, bit last);
        medians_due.push_back('{filtered: v, col: COL_BITS'(col), row: ROW_BITS'(row),
                                frame_end: last});
    endfunction

    function automatic void reset_window_model();
        shd_width    = 13'd640;
        shd_height   = 16'd480;
        shd_adaptive = 1'b0;
        for (int i = 0; i < LINE_DEPTH; i++) begin
            line_up1[i] = '0;
            line_up2[i] = '0;
        end
        for (int i = 0; i < 9; i++) begin
            win[i] = '0;
        end
        next_col = '0;
        next_row = '0;
    endfunction

    // one accepted pixel: shift the window, queue the words it completes
    function automatic void slide_window(t_pix p);
        int w, h, c, r, cm0, top;
        bit last_col, last_row;
        w = (shd_width < 2) ? 2 : ((shd_width > LINE_DEPTH) ? LINE_DEPTH : int'(shd_width));
        h = (shd_height < 2) ? 2 : int'(shd_height);
        c = next_col;
        r = next_row;
        last_col = (c >= w - 1);
        last_row = (r >= h - 1);
        for (int k = 0; k < 3; k++) begin
            win[k*3]   = win[k*3+1];
            win[k*3+1] = win[k*3+2];
        end
        win[2]      = line_up2[c];
        win[5]      = line_up1[c];
        win[8]      = p;
        line_up2[c] = line_up1[c];
        line_up1[c] = p;
        cm0 = (c >= 2) ? 0 : 2;
        if (r >= 1) begin
            top = (r >= 2) ? 0 : 2;
            if (c >= 1) begin
                push_median(window_median(top, 1, 2, cm0, 1, 2), c - 1, r - 1, 1'b0);
            end
            if (last_col) begin
                push_median(window_median(top, 1, 2, 1, 2, 1), c, r - 1, 1'b0);
            end
        end
        if (last_row) begin
            if (c >= 1) begin
                push_median(window_median(1, 2, 1, cm0, 1, 2), c - 1, r, 1'b0);
            end
            if (last_col) begin
                push_median(window_median(1, 2, 1, 1, 2, 1), c, r, 1'b1);
            end
        end
        if (last_col) begin
            next_col = '0;
            next_row = last_row ? '0 : ROW_BITS'(r + 1);
        end else begin
            next_col = COL_BITS'(c + 1);
        end
    endfunction

    function automatic t_pix make_pixel(t_pix_style style);
        case (style)
            PIX_NARROW: begin
                return t_pix'(int'($urandom_range(0, 6)) - 3);
            end
            PIX_EXTREME: begin
                return $urandom_range(0, 1) ? PIX_MAX : PIX_MIN;
            end
            PIX_IMPULSE: begin
                if ($urandom_range(0, 4) == 0) begin
                    return $urandom_range(0, 1) ? PIX_MAX : PIX_MIN;
                end
                return t_pix'(int'($urandom_range(100, 140)));
            end
            default: begin
                return t_pix'($urandom);
            end
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%0t ERROR %s", $realtime, msg);
        end
    endtask

    task automatic check_word();
        t_filt_word want;
        if (medians_due.size() == 0) begin
            report_mismatch($sformatf("unexpected word row %0d col %0d value %0d",
                                      res_bus.out_row, res_bus.out_col, res_bus.filtered));
            return;
        end
        want = medians_due.pop_front();
        words_checked++;
        if (res_bus.filtered !== want.filtered) begin
            report_mismatch($sformatf("filtered at row %0d col %0d: got %0d, expected %0d",
                                      want.row, want.col, res_bus.filtered, want.filtered));
        end
        if (res_bus.out_col !== want.col) begin
            report_mismatch($sformatf("out_col at row %0d: got %0d, expected %0d",
                                      want.row, res_bus.out_col, want.col));
        end
        if (res_bus.out_row !== want.row) begin
            report_mismatch($sformatf("out_row at col %0d: got %0d, expected %0d",
                                      want.col, res_bus.out_row, want.row));
        end
        if (res_bus.frame_end !== want.frame_end) begin
            report_mismatch($sformatf("frame_end at row %0d col %0d: got %b, expected %b",
                                      want.row, want.col, res_bus.frame_end, want.frame_end));
        end
    endtask

    // result sink: check accepted words, stall in random bursts
    always @(posedge clk) begin
        if (!rst_n) begin
            res_bus.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                check_word();
            end
            if (stall_left > 0) begin
                stall_left--;
                res_bus.ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 6);
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    task automatic send_pixel(t_pix p);
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            pix_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_bus.valid <= 1'b1;
        pix_bus.pixel <= p;
        do @(posedge clk); while (!pix_bus.ready);
        slide_window(p);
        pixels_sent++;
    endtask

    // runs to the end of the current frame
    task automatic finish_frame(t_pix_style style);
        do send_pixel(make_pixel(style)); while (next_col != 0 || next_row != 0);
        frames_done++;
    endtask

    task automatic drain_results();
        pix_bus.valid <= 1'b0;
        while (medians_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_WIDTH: begin
                shd_width = data[WIDTH_BITS-1:0];
            end
            REG_HEIGHT: begin
                shd_height = data;
            end
            REG_ADAPTIVE: begin
                shd_adaptive = data[0];
            end
            default: begin
            end
        endcase
        @(posedge clk);
    endtask

    // start with the reset sizes, then shrink the frame while row 0 is partly sent
    task automatic test_mid_frame_resize();
        send_pixel(PIX_MAX);
        send_pixel(PIX_MIN);
        send_pixel(16'sh0001);
        drain_results();
        write_reg(REG_WIDTH, 16'd4);
        write_reg(REG_HEIGHT, 16'd2);
        finish_frame(PIX_FULL);
    endtask

    // sizes below the minimum act as 2x2; spare index is ignored
    task automatic test_smallest_frames();
        t_pix corners [4];
        corners = '{PIX_MAX, PIX_MIN, -16'sd1, 16'sd0};
        drain_results();
        write_reg(REG_WIDTH, 16'd0);
        write_reg(REG_HEIGHT, 16'd1);
        write_reg(REG_SPARE, 16'hFFFF);
        foreach (corners[i]) begin
            send_pixel(corners[i]);
        end
        frames_done++;
        drain_results();
        write_reg(REG_WIDTH, 16'd1);
        write_reg(REG_HEIGHT, 16'd0);
        finish_frame(PIX_EXTREME);
    endtask

    // centre passes through unless it is the window max or min
    task automatic test_adaptive_switch();
        t_pix grid [9];
        grid = '{16'sd1, 16'sd9, 16'sd2, 16'sd8, 16'sd5, 16'sd3, 16'sd7, PIX_MAX, PIX_MIN};
        drain_results();
        write_reg(REG_ADAPTIVE, 16'd1);
        write_reg(REG_WIDTH, 16'd3);
        write_reg(REG_HEIGHT, 16'd3);
        foreach (grid[i]) begin
            send_pixel(grid[i]);
        end
        frames_done++;
    endtask

    // small random frames; some are cut short by shrinking the size mid-frame
    task automatic test_random_frames();
        int                       stop_at;
        logic [CFG_DATA_BITS-1:0] width_val;
        t_pix_style               style;
        stop_at = pixels_sent + RANDOM_PIXELS;
        while (pixels_sent < stop_at) begin
            drain_results();
            idling_on = ($urandom_range(0, 3) != 0);
            style     = t_pix_style'($urandom_range(0, 3));
            width_val = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 1))
                                                    : 16'($urandom_range(2, 12));
            write_reg(REG_WIDTH, width_val);
            write_reg(REG_ADAPTIVE, 16'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0) begin
                write_reg(REG_HEIGHT, 16'hFFFF);
                repeat ($urandom_range(1, 40)) send_pixel(make_pixel(style));
                drain_results();
                if ($urandom_range(0, 1)) begin
                    write_reg(REG_WIDTH, 16'($urandom_range(0, width_val)));
                end
                write_reg(REG_HEIGHT, 16'($urandom_range(0, next_row + 2)));
            end else begin
                write_reg(REG_HEIGHT, ($urandom_range(0, 7) == 0)
                                      ? 16'($urandom_range(0, 1)) : 16'($urandom_range(2, 7)));
            end
            finish_frame(style);
        end
    endtask

    // width at the line store depth and above it, row 0 cut short by a narrower width
    task automatic test_widest_rows();
        drain_results();
        idling_on = 1'b0;
        write_reg(REG_WIDTH, 16'd4096);
        write_reg(REG_HEIGHT, 16'd2);
        write_reg(REG_ADAPTIVE, 16'd0);
        repeat (WIDE_PIXELS) send_pixel(make_pixel(PIX_FULL));
        drain_results();
        write_reg(REG_WIDTH, 16'd8);
        finish_frame(PIX_FULL);
        drain_results();
        write_reg(REG_WIDTH, 16'hFFFF);
        write_reg(REG_ADAPTIVE, 16'd1);
        repeat (WIDE_PIXELS) send_pixel(make_pixel(PIX_IMPULSE));
        drain_results();
        write_reg(REG_WIDTH, 16'd6);
        finish_frame(PIX_IMPULSE);
    endtask

    initial begin
        reset_window_model();
        pix_bus.valid = 1'b0;
        pix_bus.pixel = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_mid_frame_resize();
        test_smallest_frames();
        test_adaptive_switch();
        test_random_frames();
        test_widest_rows();
        drain_results();
        $display("Ran %0d frames (%0d pixels), checked %0d filtered words, %0d mismatches",
                 frames_done, pixels_sent, words_checked, error_count);
        $display("Sizes 2x2 to 4096 wide, mid-frame resizes, median and adaptive modes");
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout: %0d filtered words still due", medians_due.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
src/mf3a_pkg.sv
src/mf3a_if.sv
src/mf3a_filter.sv
src/mf3a_ofifo.sv
src/median_filter_3x3_adaptive_top.sv
tb/sv/tb_top.sv
